// ===== sv/pstq_pkg.sv =====
// Package: shared constants and types for the process scheduler timer queue.
`timescale 1ns / 1ps
`default_nettype none
package pstq_pkg;
	localparam int DefProcessCount = 16;
	localparam int DefTimerEntries = 16;
	localparam int DefTimeBits     = 32;

	typedef enum logic [2:0] {
		MODE_ENQUEUE = 3'd0,
		MODE_DEQUEUE = 3'd1,
		MODE_INSERT  = 3'd2,
		MODE_CANCEL  = 3'd3,
		MODE_TICK    = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_SLEEPING = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_OVERFLOW = 2'd3
	} status_t;

	// commands from the control to every timer cell
	typedef struct packed {
		logic ins;    // insert-by-shift pass
		logic drop;   // remove entry: cells at or past drop point take right neighbor
	} cell_cmd_t;
endpackage
`default_nettype wire

// ===== sv/pstq_cell.sv =====
// Timer cell: one entry of the sorted timer queue, with shift links to its neighbors.
`timescale 1ns / 1ps
`default_nettype none
module pstq_cell
	import pstq_pkg::*;
#(
	parameter int TimeBits = DefTimeBits,
	parameter int PidBits  = 4
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire cell_cmd_t       cmd,
	input  wire                  insert_here,  // this cell takes the new entry
	input  wire                  shift_in,     // take left neighbor (insert)
	input  wire                  pull_in,      // take right neighbor (drop)
	input  wire [TimeBits-1:0]   new_time,
	input  wire [PidBits-1:0]    new_owner,
	input  wire [TimeBits-1:0]   left_time,
	input  wire [PidBits-1:0]    left_owner,
	input  wire [TimeBits-1:0]   right_time,
	input  wire [PidBits-1:0]    right_owner,
	output logic [TimeBits-1:0]  time_q,
	output logic [PidBits-1:0]   owner_q
);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q  <= '0;
			owner_q <= '0;
		end else if (cmd.ins && insert_here) begin
			time_q  <= new_time;
			owner_q <= new_owner;
		end else if (cmd.ins && shift_in) begin
			time_q  <= left_time;
			owner_q <= left_owner;
		end else if (cmd.drop && pull_in) begin
			time_q  <= right_time;
			owner_q <= right_owner;
		end
	end
endmodule
`default_nettype wire

// ===== sv/process_scheduler_timer_queue.sv =====
// Top level: process scheduler with FIFO run queue and sorted timer cell chain.
//
// Usage: one operation item enters on the s_axis channel (tvalid/tready) and
// exactly one result item leaves on the m_axis channel. Modes: enqueue,
// dequeue, timer insert, timer cancel, time tick.
// Timers live in a row of identical cells kept sorted by wrap-aware wake time;
// insert shifts the entries past the insert point one cell along, and cancel and
// tick pull the entries from the drop point one cell back. A taken item passes
// through S_TICK and then S_OUT, which raises m_axis_tvalid; a tick stays in
// S_TICK while the chain head has expired, one expired entry per cycle, until the run queue overflows.
// Throughput: one item at a time; s_axis_tready is high only while idle, so
// the next item is taken in the cycle after the result item is accepted.
// Reset (arst_n low) empties both queues and clears every ready mark; run
// slot contents need no clearing because counts guard every read.
// When the receiver stalls (m_axis_tready low) the result holds in its
// register and no new item is taken until the result is accepted.
`timescale 1ns / 1ps
`default_nettype none
module process_scheduler_timer_queue
	import pstq_pkg::*;
#(
	parameter int ProcessCount = DefProcessCount,
	parameter int TimerEntries = DefTimerEntries,
	parameter int TimeBits     = DefTimeBits
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	// mode[2:0], process_id[6:3], wake_time[38:7], now_time[70:39], zero fill
	input  wire  [71:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	// status[1:0], run_process[5:2], run_valid[6], expired_count[11:7],
	// timers_pending[12], next_wake_time[44:13], zero fill
	output logic [47:0] m_axis_tdata
);
	localparam int RunIdx = (ProcessCount > 1) ? $clog2(ProcessCount) : 1;
	localparam int RunCnt = $clog2(ProcessCount + 1);
	localparam int TmCnt  = $clog2(TimerEntries + 1);
	localparam int PidW   = 4;

	typedef enum logic [1:0] {S_IDLE, S_TICK, S_OUT} state_t;
	state_t state_q;

	// latched item
	logic [2:0]          mode_q;
	logic [PidW-1:0]     pid_q;
	logic [TimeBits-1:0] wake_q, now_q;

	// run queue memory and pointers
	logic [PidW-1:0]   run_mem [ProcessCount];
	logic [RunIdx-1:0] run_head_q, run_tail_q;
	logic [RunCnt-1:0] run_count_q;
	logic [ProcessCount-1:0] ready_q;
	logic [TmCnt-1:0]  tcount_q;

	// result fields
	logic [1:0] status_q;
	logic [PidW-1:0] rproc_q;
	logic rvalid_q;
	logic [4:0] exp_q;

	// cell chain
	logic [TimeBits-1:0] ctime [TimerEntries];
	logic [PidW-1:0]     cown  [TimerEntries];
	logic [TimerEntries-1:0] valid_c, after_c, match_c, ins_here, shift_in, pull_in;
	cell_cmd_t cmd;

	logic pid_ok, run_full, timer_full, head_expired, head_ready;
	logic [TimeBits-1:0] diff_h;

	assign pid_ok     = 32'(pid_q) < 32'(ProcessCount);
	assign run_full   = run_count_q == RunCnt'(ProcessCount);
	assign timer_full = tcount_q == TmCnt'(TimerEntries);
	assign diff_h     = ctime[0] - now_q;
	assign head_expired = (tcount_q != '0) &&
		!((diff_h != '0) && !diff_h[TimeBits-1]);
	assign head_ready = ready_q[cown[0][RunIdx-1:0]];

	// per-cell compare: entry is later than the new wake time; owner match
	always_comb begin
		logic [TimeBits-1:0] d;
		logic cand, seen_ins, seen_match;
		seen_ins = 1'b0;
		seen_match = 1'b0;
		for (int i = 0; i < TimerEntries; i++) begin
			d = ctime[i] - wake_q;
			valid_c[i] = 32'(i) < 32'(tcount_q);
			after_c[i] = valid_c[i] && (d != '0) && !d[TimeBits-1];
			match_c[i] = valid_c[i] && (cown[i] == pid_q);
		end
		// insert point: first entry later than the new time, or the end;
		// cells past it take their left neighbor.
		// drop point: first match (cancel) or head (tick); all cells from there pull
		for (int i = 0; i < TimerEntries; i++) begin
			cand = !valid_c[i] || after_c[i];
			ins_here[i] = cand && !seen_ins;
			shift_in[i] = seen_ins;
			seen_ins = seen_ins | cand;
			seen_match = seen_match | match_c[i];
			pull_in[i] = (mode_q == MODE_TICK) ? 1'b1 : seen_match;
		end
	end

	logic cancel_hit;
	assign cancel_hit = |match_c;

	always_comb begin
		cmd.ins  = 1'b0;
		cmd.drop = 1'b0;
		if (state_q == S_TICK) begin
			case (mode_q)
				MODE_INSERT: cmd.ins  = pid_ok && !timer_full;
				MODE_CANCEL: cmd.drop = pid_ok && cancel_hit;
				MODE_TICK:   cmd.drop = head_expired && (head_ready || !run_full);
				default: ;
			endcase
		end
	end

	for (genvar g = 0; g < TimerEntries; g++) begin : g_cell
		localparam int R = (g + 1 < TimerEntries) ? g + 1 : g;
		localparam int L = (g > 0) ? g - 1 : 0;
		pstq_cell #(.TimeBits(TimeBits), .PidBits(PidW)) u_cell (
			.clk, .arst_n, .cmd,
			.insert_here(ins_here[g]), .shift_in(shift_in[g]),
			.pull_in(pull_in[g] && (g + 1 < TimerEntries)),
			.new_time(wake_q), .new_owner(pid_q),
			.left_time(ctime[L]), .left_owner(cown[L]),
			.right_time(ctime[R]), .right_owner(cown[R]),
			.time_q(ctime[g]), .owner_q(cown[g])
		);
	end

	assign s_axis_tready = (state_q == S_IDLE);

	logic [RunIdx-1:0] head_nx, tail_nx;
	assign head_nx = (32'(run_head_q) + 1 >= ProcessCount) ? '0 : run_head_q + 1'b1;
	assign tail_nx = (32'(run_tail_q) + 1 >= ProcessCount) ? '0 : run_tail_q + 1'b1;

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && s_axis_tvalid) begin
			mode_q <= s_axis_tdata[2:0];
			pid_q  <= s_axis_tdata[6:3];
			wake_q <= TimeBits'(s_axis_tdata[38:7]);
			now_q  <= TimeBits'(s_axis_tdata[70:39]);
		end
		if (state_q == S_TICK) begin
			if ((mode_q == MODE_ENQUEUE && pid_ok && !run_full) ||
			    (mode_q == MODE_TICK && head_expired && !head_ready && !run_full))
				run_mem[run_tail_q] <= (mode_q == MODE_TICK) ? cown[0] : pid_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			run_head_q <= '0; run_tail_q <= '0; run_count_q <= '0;
			tcount_q <= '0; ready_q <= '0;
			status_q <= ST_OK; rproc_q <= '0; rvalid_q <= 1'b0; exp_q <= '0;
			m_axis_tvalid <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						state_q <= S_TICK;
						status_q <= ST_OK; rproc_q <= '0; rvalid_q <= 1'b0; exp_q <= '0;
					end
				end
				S_TICK: begin
					state_q <= S_OUT;
					case (mode_q)
						MODE_ENQUEUE: if (pid_ok) begin
							if (run_full) status_q <= ST_OVERFLOW;
							else begin
								run_tail_q <= tail_nx;
								run_count_q <= run_count_q + 1'b1;
								ready_q[pid_q[RunIdx-1:0]] <= 1'b1;
							end
						end
						MODE_DEQUEUE: begin
							if (run_count_q != '0) begin
								rproc_q <= run_mem[run_head_q];
								rvalid_q <= 1'b1;
								ready_q[run_mem[run_head_q][RunIdx-1:0]] <= 1'b0;
								run_head_q <= head_nx;
								run_count_q <= run_count_q - 1'b1;
							end else
								status_q <= (tcount_q != '0) ? ST_SLEEPING : ST_EMPTY;
						end
						MODE_INSERT: if (pid_ok) begin
							if (timer_full) status_q <= ST_OVERFLOW;
							else tcount_q <= tcount_q + 1'b1;
						end
						MODE_CANCEL: if (cmd.drop) tcount_q <= tcount_q - 1'b1;
						MODE_TICK: begin
							if (head_expired) begin
								if (!head_ready && run_full) status_q <= ST_OVERFLOW;
								else begin
									state_q <= S_TICK;  // walk on to the next head
									if (!head_ready) begin
										run_tail_q <= tail_nx;
										run_count_q <= run_count_q + 1'b1;
										ready_q[cown[0][RunIdx-1:0]] <= 1'b1;
									end
									tcount_q <= tcount_q - 1'b1;
									if (exp_q != 5'd31) exp_q <= exp_q + 1'b1;
								end
							end
						end
						default: ;
					endcase
				end
				S_OUT: begin
					if (m_axis_tvalid && m_axis_tready) begin
						m_axis_tvalid <= 1'b0;
						state_q <= S_IDLE;
					end else
						m_axis_tvalid <= 1'b1;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	logic pend;
	assign pend = tcount_q != '0;
	always_comb begin
		m_axis_tdata = '0;
		m_axis_tdata[1:0]   = status_q;
		m_axis_tdata[5:2]   = rproc_q;
		m_axis_tdata[6]     = rvalid_q;
		m_axis_tdata[11:7]  = exp_q;
		m_axis_tdata[12]    = pend;
		m_axis_tdata[44:13] = pend ? 32'(ctime[0]) : 32'd0;
	end
endmodule
`default_nettype wire
